[rtl/kwm_pkg.sv]
package kwm_pkg;

  localparam int unsigned RUNS_DEF   = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned RUN_IDX_W  = 3;
  localparam int unsigned LSN_W      = 64;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned CFG_W      = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RUNS_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EXHAUST = 2'd1,
    CMD_POP     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [LSN_W-1:0] commit_pos;
    logic [LSN_W-1:0] record_pos;
    logic [TAG_W-1:0] tag;
  } head_t;

endpackage

[rtl/kwm_cmd_if.sv]
interface kwm_cmd_if;
  import kwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [RUN_IDX_W-1:0] run_index;
  logic [LSN_W-1:0]     commit_pos;
  logic [LSN_W-1:0]     record_pos;
  logic [TAG_W-1:0]     tag;

  modport source (
    output valid, command, run_index, commit_pos, record_pos, tag,
    input  ready
  );

  modport sink (
    input  valid, command, run_index, commit_pos, record_pos, tag,
    output ready
  );

endinterface

[rtl/kwm_res_if.sv]
interface kwm_res_if;
  import kwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [RUN_IDX_W-1:0] best_run;
  logic [LSN_W-1:0]     out_commit_pos;
  logic [LSN_W-1:0]     out_record_pos;
  logic [TAG_W-1:0]     out_tag;

  modport source (
    output valid, found, best_run, out_commit_pos, out_record_pos, out_tag,
    input  ready
  );

  modport sink (
    input  valid, found, best_run, out_commit_pos, out_record_pos, out_tag,
    output ready
  );

endinterface

[rtl/kway_merge_descending_lsn.sv]
// Head selector for a descending k-way merge of presorted runs.
// Command channel cmd_i carries load, exhausted and pop words. A load writes
// the head of one run slot and marks it valid; an exhausted word clears the
// valid mark of a slot. Both give no result.
// A pop scans slots 0 to min(active_runs, RUNS)-1 through one registered
// head memory read port and one 128-bit comparator, one slot per cycle.
// The best head (largest commit, then record position, lowest slot on a
// tie) goes to the result channel res_o and its slot is cleared. With no
// valid head the result has found low and all other fields zero.
// A pop's result goes to the output register at the end of its scan; no
// further command is taken until the block is back in idle after that write.
// The result sits in an output register: while the receiver stalls, loads
// and exhausted words are still taken, and a further pop waits at the end of
// its scan until the held result is taken.
// The cfg write channel sets active_runs and is always ready.
// Reset clears all valid marks and sets active_runs to 8; head contents are
// not cleared.
module kway_merge_descending_lsn #(
  parameter int unsigned RUNS = kwm_pkg::RUNS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kwm_cmd_if.sink                  cmd_i,
  kwm_res_if.source                res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_data_i
);
  import kwm_pkg::*;

  localparam int unsigned IW = (RUNS > 1) ? $clog2(RUNS) : 1;
  localparam int unsigned CW = $clog2(RUNS + 1);

  state_e          state_q, state_d;
  logic [CFG_W-1:0] active_runs_q;
  logic [RUNS-1:0] valid_q, valid_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   limit_q, limit_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   pend_idx_q, pend_idx_d;
  logic            have_q, have_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  head_t           best_q, best_d;

  logic            out_vld_q, out_vld_d;
  logic            out_found_q;
  logic [IW-1:0]   out_run_q;
  head_t           out_head_q;

  head_t           mem [RUNS];
  head_t           rdata_q;
  logic            mem_we;
  logic [IW-1:0]   wr_addr;
  logic [IW-1:0]   rd_addr;
  head_t           wdata;

  logic            cmd_acc;
  logic            slot_ok;
  logic            issue;
  logic            greater;
  logic            out_take;
  logic            out_fire;
  logic [CW-1:0]   limit_new;

  assign cmd_acc  = cmd_i.valid && cmd_i.ready;
  assign slot_ok  = {5'd0, cmd_i.run_index} < 8'(RUNS);
  assign issue    = cnt_q < limit_q;
  assign greater  = {rdata_q.commit_pos, rdata_q.record_pos} >
                    {best_q.commit_pos, best_q.record_pos};
  assign out_take = out_vld_q && res_o.ready;
  assign out_fire = (state_q == ST_DONE) && (!out_vld_q || res_o.ready);
  assign limit_new = ({4'd0, active_runs_q} > 8'(RUNS)) ? CW'(RUNS)
                                                         : CW'(active_runs_q);
  assign wr_addr  = IW'(cmd_i.run_index);
  assign rd_addr  = cnt_q[IW-1:0];
  assign wdata    = '{commit_pos: cmd_i.commit_pos, record_pos: cmd_i.record_pos,
                      tag: cmd_i.tag};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc && cmd_i.command == CMD_POP) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // The last pending compare lands in the same edge that leaves the scan.
        if (!issue) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    cmd_i.ready = 1'b0;
    mem_we      = 1'b0;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_acc) begin
          if (cmd_i.command == CMD_LOAD && slot_ok) begin
            mem_we           = 1'b1;
            valid_d[wr_addr] = 1'b1;
          end else if (cmd_i.command == CMD_EXHAUST && slot_ok) begin
            valid_d[wr_addr] = 1'b0;
          end else if (cmd_i.command == CMD_POP) begin
            cnt_d   = '0;
            limit_d = limit_new;
            have_d  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // Read of slot cnt is issued here; its data is compared next cycle.
        if (issue) begin
          cnt_d      = cnt_q + CW'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_addr;
        end
        if (pend_q && valid_q[pend_idx_q] && (!have_q || greater)) begin
          have_d     = 1'b1;
          best_idx_d = pend_idx_q;
          best_d     = rdata_q;
        end
      end
      ST_DONE: begin
        if (out_fire && have_q) valid_d[best_idx_q] = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_fire) begin
      out_vld_d = 1'b1;
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_runs_q <= ACTIVE_RUNS_RST;
      valid_q       <= '0;
      cnt_q         <= '0;
      limit_q       <= '0;
      pend_q        <= 1'b0;
      have_q        <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      limit_q   <= limit_d;
      pend_q    <= pend_d;
      have_q    <= have_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) active_runs_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    if (out_fire) begin
      out_found_q <= have_q;
      out_run_q   <= have_q ? best_idx_q : '0;
      out_head_q  <= have_q ? best_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  assign cfg_ready_o          = 1'b1;
  assign res_o.valid          = out_vld_q;
  assign res_o.found          = out_found_q;
  assign res_o.best_run       = RUN_IDX_W'(out_run_q);
  assign res_o.out_commit_pos = out_head_q.commit_pos;
  assign res_o.out_record_pos = out_head_q.record_pos;
  assign res_o.out_tag        = out_head_q.tag;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import kwm_pkg::*;

  localparam int unsigned RUNS = RUNS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 91;
  localparam int PRESSURE_PHASE = 2;
  localparam logic [63:0] MAX64 = '1;

  typedef struct packed {
    logic                 found;
    logic [RUN_IDX_W-1:0] run;
    logic [LSN_W-1:0]     commit;
    logic [LSN_W-1:0]     record;
    logic [TAG_W-1:0]     tag;
  } merge_res_t;

  localparam merge_res_t NONE = '0;

  // For a row with is_cfg set, the new scan length sits in the low bits of tag.
  typedef struct {
    bit                   is_cfg;
    logic [CMD_W-1:0]     cmd;
    logic [RUN_IDX_W-1:0] slot;
    logic [LSN_W-1:0]     commit;
    logic [LSN_W-1:0]     record;
    logic [TAG_W-1:0]     tag;
    bit                   chk;
    merge_res_t           want;
  } row_t;

  localparam logic [CFG_W-1:0] PHASE_RUNS [8] =
    '{4'd1, 4'd15, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2, 4'd8};

  row_t dir_tab [0:24] = '{
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1, NONE},
    '{1'b0, CMD_LOAD,    3'd0, MAX64, 64'd0, 32'hFFFF_FFFF, 1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd7, MAX64, MAX64, 32'd0,         1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd7, MAX64, MAX64, 32'd0}},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd0, MAX64, 64'd0, 32'hFFFF_FFFF}},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1, NONE},
    '{1'b0, CMD_LOAD,    3'd3, 64'd5, 64'd9, 32'hA5A5_A5A5, 1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd5, 64'd5, 64'd9, 32'h5A5A_5A5A, 1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd3, 64'd5, 64'd9, 32'hA5A5_A5A5}},
    '{1'b0, CMD_EXHAUST, 3'd5, 64'd0, 64'd0, 32'd0,         1'b0, NONE},
    '{1'b0, CMD_EXHAUST, 3'd5, 64'd0, 64'd0, 32'd0,         1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1, NONE},
    '{1'b0, CMD_LOAD,    3'd2, 64'd0, 64'd0, 32'd1,         1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd2, 64'd1, 64'd0, 32'd2,         1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd6, 64'd0, MAX64, 32'd3,         1'b0, NONE},
    '{1'b0, CMD_UNUSED,  3'd4, MAX64, MAX64, 32'hFFFF_FFFF, 1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd2, 64'd1, 64'd0, 32'd2}},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd6, 64'd0, MAX64, 32'd3}},
    '{1'b1, CMD_LOAD,    3'd0, 64'd0, 64'd0, 32'd0,         1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd1, 64'd7, 64'd7, 32'h11,        1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1, NONE},
    '{1'b1, CMD_LOAD,    3'd0, 64'd0, 64'd0, 32'd15,        1'b0, NONE},
    '{1'b0, CMD_LOAD,    3'd7, 64'd9, 64'd0, 32'h77,        1'b0, NONE},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd7, 64'd9, 64'd0, 32'h77}},
    '{1'b0, CMD_POP,     3'd0, 64'd0, 64'd0, 32'd0,         1'b1,
      {1'b1, 3'd1, 64'd7, 64'd7, 32'h11}}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  kwm_cmd_if cmd_if ();
  kwm_res_if res_if ();

  kway_merge_descending_lsn u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .res_o       (res_if),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the run heads and the scan length.
  bit               slot_live   [RUNS];
  logic [LSN_W-1:0] slot_commit [RUNS];
  logic [LSN_W-1:0] slot_record [RUNS];
  logic [TAG_W-1:0] slot_tag    [RUNS];
  logic [CFG_W-1:0] scan_len = ACTIVE_RUNS_RST;

  merge_res_t expected_heads [$];
  int err_cnt = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int phase_no = -1;

  int hold_left = 0;
  bit held_once = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;
  logic [15:0] stall_pat = 16'hA5C3;

  always #5 clk_i = ~clk_i;

  // Applies one command word to the shadow heads; returns 1 when it yields a result.
  function automatic bit step_heads(input logic [CMD_W-1:0] cmd,
                                    input logic [RUN_IDX_W-1:0] slot,
                                    input logic [LSN_W-1:0] c, input logic [LSN_W-1:0] r,
                                    input logic [TAG_W-1:0] t, output merge_res_t res);
    int unsigned lim;
    int best;
    bit have;
    res = '0;
    best = 0;
    have = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        if (slot < RUNS) begin
          slot_live[slot] = 1'b1;
          slot_commit[slot] = c;
          slot_record[slot] = r;
          slot_tag[slot] = t;
        end
        return 1'b0;
      end
      CMD_EXHAUST: begin
        if (slot < RUNS) slot_live[slot] = 1'b0;
        return 1'b0;
      end
      CMD_POP: begin
        lim = (32'(scan_len) > RUNS) ? RUNS : 32'(scan_len);
        for (int i = 0; i < lim; i++) begin
          // Strictly greater keeps the lowest slot on equal keys.
          if (slot_live[i] && (!have || {slot_commit[i], slot_record[i]} >
                                        {slot_commit[best], slot_record[best]})) begin
            best = i;
            have = 1'b1;
          end
        end
        if (have) begin
          res = {1'b1, RUN_IDX_W'(best), slot_commit[best], slot_record[best], slot_tag[best]};
          slot_live[best] = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [LSN_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 3));
      1: return MAX64 - 64'($urandom_range(0, 2));
      2: return {32'd0, 32'($urandom_range(0, 7))} << $urandom_range(0, 60);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_cnt < 40) $display("mismatch %s: got %h expected %h", what, got, want);
    err_cnt++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [RUN_IDX_W-1:0] slot,
                           input logic [LSN_W-1:0] c, input logic [LSN_W-1:0] r,
                           input logic [TAG_W-1:0] t, input bit typed, input merge_res_t want);
    merge_res_t pred;
    cmd_if.valid <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.run_index <= slot;
    cmd_if.commit_pos <= c;
    cmd_if.record_pos <= r;
    cmd_if.tag <= t;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (step_heads(cmd, slot, c, r, t, pred)) expected_heads.push_back(typed ? want : pred);
  endtask

  // Loads and exhausted words give no result, so let a full scan drain before writing.
  task automatic write_active_runs(input logic [CFG_W-1:0] v);
    cmd_if.valid <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk_i);
    repeat (RUNS + 6) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scan_len = v;
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin
    merge_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_heads.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(res_if.best_run), 64'd0);
      end else begin
        want = expected_heads.pop_front();
        if (res_if.found !== want.found)
          report_mismatch("found", 64'(res_if.found), 64'(want.found));
        if (res_if.best_run !== want.run)
          report_mismatch("best_run", 64'(res_if.best_run), 64'(want.run));
        if (res_if.out_commit_pos !== want.commit)
          report_mismatch("out_commit_pos", res_if.out_commit_pos, want.commit);
        if (res_if.out_record_pos !== want.record)
          report_mismatch("out_record_pos", res_if.out_record_pos, want.record);
        if (res_if.out_tag !== want.tag)
          report_mismatch("out_tag", 64'(res_if.out_tag), 64'(want.tag));
      end
    end
  end

  // Receiver: one long hold-off in the pressure phase, otherwise randomly chosen stall modes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (phase_no == PRESSURE_PHASE && !held_once) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
      res_if.ready <= 1'b0;
    end else if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(32, 256);
      stall_pat <= 16'($urandom);
      res_if.ready <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          res_if.ready <= stall_pat[0];
          stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [RUN_IDX_W-1:0] slot;
    int unsigned lim;
    int roll;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_LOAD;
    cmd_if.run_index = '0;
    cmd_if.commit_pos = '0;
    cmd_if.record_pos = '0;
    cmd_if.tag = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < RUNS; i++) slot_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_active_runs(dir_tab[i].tag[CFG_W-1:0]);
      end else begin
        pace();
        send_word(dir_tab[i].cmd, dir_tab[i].slot, dir_tab[i].commit, dir_tab[i].record,
                  dir_tab[i].tag, dir_tab[i].chk, dir_tab[i].want);
      end
    end

    foreach (PHASE_RUNS[p]) begin
      write_active_runs(PHASE_RUNS[p]);
      phase_no = p;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) cmd = CMD_LOAD;
        else if (roll < 85) cmd = CMD_POP;
        else if (roll < 95) cmd = CMD_EXHAUST;
        else cmd = CMD_UNUSED;
        // Aim most slots inside the scanned range so pops have real work to do.
        lim = (32'(scan_len) > RUNS) ? RUNS : 32'(scan_len);
        if (lim == 0 || $urandom_range(0, 3) == 0) slot = RUN_IDX_W'($urandom_range(0, RUNS - 1));
        else slot = RUN_IDX_W'($urandom_range(0, lim - 1));
        no_gaps = (p == PRESSURE_PHASE && n < 60);
        pace();
        send_word(cmd, slot, rand_key(), rand_key(), $urandom, 1'b0, NONE);
      end
    end

    cmd_if.valid <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk_i);
    repeat (RUNS + 8) @(posedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/kwm_pkg.sv
rtl/kwm_cmd_if.sv
rtl/kwm_res_if.sv
rtl/kway_merge_descending_lsn.sv
tb/tb.sv
